[design/ktcv_pkg.sv]
// Package with shared types, constants and command codes of the tracker.
`timescale 1ns / 1ps
package ktcv_pkg;
   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [1:0] {
      CMD_INIT    = 2'd0,
      CMD_PREDICT = 2'd1,
      CMD_UPDATE  = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   localparam logic CSR_ACCEL = 1'b0;
   localparam logic CSR_MEAS  = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic signed [31:0] meas_x;
      logic signed [31:0] meas_y;
      logic [23:0] time_step;
   } req_type_t_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [30:0] var_pos_x;
      logic [30:0] var_pos_y;
      logic signed [31:0] cov_x_vx;
      logic signed [31:0] cov_y_vy;
      logic [30:0] var_vel_x;
      logic [30:0] var_vel_y;
   } rsp_type;

   typedef struct packed {
      logic        index;
      logic [23:0] data;
   } csr_type;

   // Saturate a wide signed value to the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // Clamp to the variance range: negative reads as zero.
   function automatic logic signed [31:0] satv(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v < 66'sd0) r = 32'sd0;
      else r = sat32(v);
      return r;
   endfunction
endpackage

[design/ktcv_if.sv]
// Valid-ready channel interfaces for request, response and register writes.
`timescale 1ns / 1ps
interface ktcv_req_if;
   logic valid;
   logic ready;
   ktcv_pkg::req_type_t_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface ktcv_rsp_if;
   logic valid;
   logic ready;
   ktcv_pkg::rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface ktcv_csr_if;
   logic valid;
   logic ready;
   ktcv_pkg::csr_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

[design/kalman_tracker_cv2d_unit.sv]
// Top level of the two-axis constant-velocity Kalman tracker.
// Init and unknown commands go from idle straight to the output stage; predict steps through
// the shared multiplier; update also runs two bit-serial divisions per axis, and an axis
// with a non-positive divisor skips both. Values are Q16.16 at the default FRAC_BITS.
// Throughput: one command at a time; the next is taken the cycle after the result has left.
// Reset: state zero, covariance diagonal one, both sigmas 65536 (one at Q16.16), no result pending.
`timescale 1ns / 1ps
module kalman_tracker_cv2d_unit #(
   parameter int FRAC_BITS = ktcv_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   ktcv_req_if.sink   req,
   ktcv_rsp_if.source rsp,
   ktcv_csr_if.sink   csr
);
   import ktcv_pkg::*;

   localparam int DW = FRAC_BITS + 33;          // divider quotient bits
   localparam int CW = $clog2(DW + 1);
   localparam logic signed [65:0] RND = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] TEN = 32'sd10 <<< FRAC_BITS;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_DIV  = 5'b00100,
      S_STEP = 5'b01000,
      S_OUT  = 5'b10000
   } st_type;

   // Operand selectors for the shared multiplier.
   typedef enum logic [3:0] {
      M_SS, M_TT, M_T2T, M_T3T, M_SAT2, M_SAT3, M_SAT4, M_VT, M_TV, M_TC, M_TE,
      M_K0D, M_K1D, M_K0P, M_K0C, M_K1C
   } mop_type;

   st_type state_ff, state_in;
   logic [4:0] pc_ff, pc_in;
   logic       ax_ff, ax_in;
   cmd_type    cmd_ff;
   logic signed [31:0] mx_ff, my_ff;
   logic [23:0] ts_ff, accel_ff, meas_ff;
   logic signed [31:0] sv_ff [4];
   logic signed [31:0] cd_ff [4];
   logic signed [31:0] cc_ff [2];
   logic signed [31:0] sq_ff, t2_ff, t3_ff, t4_ff, q11_ff, q01_ff, q00_ff, e_ff, np_ff;
   logic signed [31:0] s_ff, k0_ff, k1_ff, d_ff;
   logic signed [31:0] mres_ff;
   logic               mdone_ff;
   rsp_type out_ff;
   logic    out_v_ff;

   // Divider state: restoring, one quotient bit per cycle on magnitudes.
   logic [DW-1:0] dq_ff;
   logic [32:0]   dr_ff;
   logic [CW-1:0] dc_ff;
   logic          dneg_ff, dk_ff;

   logic signed [31:0] p, c, v, z, pos, vel;
   assign p   = cd_ff[{1'b0, ax_ff}];
   assign v   = cd_ff[{1'b1, ax_ff}];
   assign c   = cc_ff[ax_ff];
   assign pos = sv_ff[{1'b0, ax_ff}];
   assign vel = sv_ff[{1'b1, ax_ff}];
   assign z   = ax_ff ? my_ff : mx_ff;

   // Shared multiplier operand selection and rounding.
   mop_type mop;
   logic signed [31:0] ma, mb;
   logic signed [65:0] mprod;
   logic signed [31:0] mq;
   logic signed [31:0] tsx;
   assign tsx = {8'd0, ts_ff};
   always_comb begin
      ma = 32'sd0;
      mb = 32'sd0;
      case (mop)
         M_SS:   begin ma = cmd_ff == CMD_PREDICT ? {8'd0, accel_ff} : {8'd0, meas_ff};
                       mb = ma; end
         M_TT:   begin ma = tsx; mb = tsx; end
         M_T2T:  begin ma = t2_ff; mb = tsx; end
         M_T3T:  begin ma = t3_ff; mb = tsx; end
         M_SAT2: begin ma = sq_ff; mb = t2_ff; end
         M_SAT3: begin ma = sq_ff; mb = t3_ff; end
         M_SAT4: begin ma = sq_ff; mb = t4_ff; end
         M_VT:   begin ma = vel; mb = tsx; end
         M_TV:   begin ma = tsx; mb = v; end
         M_TC:   begin ma = tsx; mb = c; end
         M_TE:   begin ma = tsx; mb = e_ff; end
         M_K0D:  begin ma = k0_ff; mb = d_ff; end
         M_K1D:  begin ma = k1_ff; mb = d_ff; end
         M_K0P:  begin ma = k0_ff; mb = p; end
         M_K0C:  begin ma = k0_ff; mb = c; end
         M_K1C:  begin ma = k1_ff; mb = c; end
         default: begin ma = 32'sd0; mb = 32'sd0; end
      endcase
      mprod = 66'(ma) * 66'(mb);
      mq = sat32((mprod + RND) >>> FRAC_BITS);
   end

   // Micro-program: each multiply step selects one product, which is stored or added in that same step.
   // Predict uses steps 0..10 (7..10 per axis); update uses 0 and 12..20 around the divider.
   always_comb begin
      case (pc_ff)
         5'd0:  mop = M_SS;
         5'd1:  mop = M_TT;
         5'd2:  mop = M_T2T;
         5'd3:  mop = M_T3T;
         5'd4:  mop = M_SAT2;
         5'd5:  mop = M_SAT3;
         5'd6:  mop = M_SAT4;
         5'd7:  mop = M_VT;
         5'd8:  mop = M_TV;
         5'd9:  mop = M_TC;
         5'd10: mop = M_TE;
         5'd16: mop = M_K0D;
         5'd17: mop = M_K1D;
         5'd18: mop = M_K0P;
         5'd19: mop = M_K0C;
         5'd20: mop = M_K1C;
         default: mop = M_SS;
      endcase
   end

   assign req.ready = state_ff == S_IDLE && !out_v_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

   logic [32:0] dtrial;
   always_comb begin
      dtrial = {dr_ff[31:0], dq_ff[DW-1]} - {1'b0, s_ff};
   end

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         accel_ff <= 24'(65536);
         meas_ff  <= 24'(65536);
         for (int i = 0; i < 4; i++) begin
            sv_ff[i] <= 32'sd0;
            cd_ff[i] <= ONE;
         end
         cc_ff[0] <= 32'sd0;
         cc_ff[1] <= 32'sd0;
         pc_ff <= 5'd0;
         ax_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            if (csr.data.index == CSR_ACCEL) accel_ff <= csr.data.data;
            else meas_ff <= csr.data.data;
         end
         if (rsp.valid && rsp.ready) out_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  cmd_ff <= cmd_type'(req.data.req_type);
                  mx_ff  <= req.data.meas_x;
                  my_ff  <= req.data.meas_y;
                  ts_ff  <= req.data.time_step;
                  ax_ff  <= 1'b0;
                  pc_ff  <= 5'd0;
                  if (req.data.req_type == CMD_INIT) begin
                     sv_ff[0] <= req.data.meas_x;
                     sv_ff[1] <= req.data.meas_y;
                     sv_ff[2] <= 32'sd0;
                     sv_ff[3] <= 32'sd0;
                     cd_ff[0] <= ONE;
                     cd_ff[1] <= ONE;
                     cd_ff[2] <= TEN;
                     cd_ff[3] <= TEN;
                     cc_ff[0] <= 32'sd0;
                     cc_ff[1] <= 32'sd0;
                     state_ff <= S_OUT;
                  end else if (req.data.req_type == CMD_PREDICT ||
                               req.data.req_type == CMD_UPDATE) begin
                     state_ff <= S_MUL;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_MUL: begin
               // Step through one multiply per cycle.
               case (pc_ff)
                  5'd0: begin
                     sq_ff <= mq;
                     if (cmd_ff == CMD_PREDICT) pc_ff <= 5'd1;
                     else pc_ff <= 5'd12;
                  end
                  5'd1: begin t2_ff <= mq; pc_ff <= 5'd2; end
                  5'd2: begin t3_ff <= mq; pc_ff <= 5'd3; end
                  5'd3: begin t4_ff <= mq; pc_ff <= 5'd4; end
                  5'd4: begin q11_ff <= mq; pc_ff <= 5'd5; end
                  5'd5: begin q01_ff <= mq >>> 1; pc_ff <= 5'd6; end
                  5'd6: begin q00_ff <= mq >>> 2; pc_ff <= 5'd7; end
                  5'd7: begin
                     sv_ff[{1'b0, ax_ff}] <= sat32(66'(pos) + 66'(mq));
                     pc_ff <= 5'd8;
                  end
                  5'd8: begin e_ff <= sat32(66'(c) + 66'(mq)); pc_ff <= 5'd9; end
                  5'd9: begin np_ff <= sat32(66'(p) + 66'(mq)); pc_ff <= 5'd10; end
                  5'd10: begin
                     cd_ff[{1'b0, ax_ff}] <=
                        satv(66'(sat32(66'(np_ff) + 66'(mq))) + 66'(q00_ff));
                     cc_ff[ax_ff] <= sat32(66'(e_ff) + 66'(q01_ff));
                     cd_ff[{1'b1, ax_ff}] <= satv(66'(v) + 66'(q11_ff));
                     if (ax_ff) state_ff <= S_OUT;
                     else begin ax_ff <= 1'b1; pc_ff <= 5'd7; end
                  end
                  5'd12: begin
                     // Innovation divisor and difference, then divide for k0.
                     s_ff <= sat32(66'(p) + 66'(sq_ff));
                     d_ff <= sat32(66'(z) - 66'(pos));
                     pc_ff <= 5'd13;
                  end
                  5'd13: begin
                     if (s_ff <= 32'sd0) begin
                        k0_ff <= 32'sd0;
                        k1_ff <= 32'sd0;
                        pc_ff <= 5'd16;
                     end else begin
                        dk_ff <= 1'b0;
                        dneg_ff <= p[31];
                        dq_ff <= DW'((p[31] ? -66'(p) : 66'(p)) <<< FRAC_BITS);
                        dr_ff <= 33'd0;
                        dc_ff <= CW'(DW);
                        state_ff <= S_DIV;
                     end
                  end
                  5'd14: begin
                     dk_ff <= 1'b1;
                     dneg_ff <= c[31];
                     dq_ff <= DW'((c[31] ? -66'(c) : 66'(c)) <<< FRAC_BITS);
                     dr_ff <= 33'd0;
                     dc_ff <= CW'(DW);
                     state_ff <= S_DIV;
                  end
                  5'd16: begin
                     sv_ff[{1'b0, ax_ff}] <= sat32(66'(pos) + 66'(mq));
                     pc_ff <= 5'd17;
                  end
                  5'd17: begin
                     sv_ff[{1'b1, ax_ff}] <= sat32(66'(vel) + 66'(mq));
                     pc_ff <= 5'd18;
                  end
                  5'd18: begin np_ff <= satv(66'(p) - 66'(mq)); pc_ff <= 5'd19; end
                  5'd19: begin e_ff <= sat32(66'(c) - 66'(mq)); pc_ff <= 5'd20; end
                  5'd20: begin
                     cd_ff[{1'b1, ax_ff}] <= satv(66'(v) - 66'(mq));
                     cd_ff[{1'b0, ax_ff}] <= np_ff;
                     cc_ff[ax_ff] <= e_ff;
                     if (ax_ff) state_ff <= S_OUT;
                     else begin ax_ff <= 1'b1; pc_ff <= 5'd12; end
                  end
                  default: pc_ff <= 5'd0;
               endcase
            end
            S_DIV: begin
               // One restoring step per cycle; the quotient shifts into dq_ff.
               if (dc_ff != '0) begin
                  if (!dtrial[32]) begin
                     dr_ff <= dtrial;
                     dq_ff <= {dq_ff[DW-2:0], 1'b1};
                  end else begin
                     dr_ff <= {dr_ff[31:0], dq_ff[DW-1]};
                     dq_ff <= {dq_ff[DW-2:0], 1'b0};
                  end
                  dc_ff <= dc_ff - 1'b1;
               end else begin
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               // Sign and saturate the quotient into the gain.
               if (!dk_ff) begin
                  k0_ff <= sat32(dneg_ff ? -66'(dq_ff) : 66'(dq_ff));
                  pc_ff <= 5'd14;
               end else begin
                  k1_ff <= sat32(dneg_ff ? -66'(dq_ff) : 66'(dq_ff));
                  pc_ff <= 5'd16;
               end
               state_ff <= S_MUL;
            end
            S_OUT: begin
               out_ff.pos_x <= sv_ff[0];
               out_ff.pos_y <= sv_ff[1];
               out_ff.vel_x <= sv_ff[2];
               out_ff.vel_y <= sv_ff[3];
               out_ff.var_pos_x <= cd_ff[0][30:0];
               out_ff.var_pos_y <= cd_ff[1][30:0];
               out_ff.var_vel_x <= cd_ff[2][30:0];
               out_ff.var_vel_y <= cd_ff[3][30:0];
               out_ff.cov_x_vx <= cc_ff[0];
               out_ff.cov_y_vy <= cc_ff[1];
               out_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // A result is never overwritten while it waits.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data)) else $error("result lost");
   // No request is taken while a result waits.
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("overlap");
   // The divider runs only with a positive divisor.
   a_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> s_ff > 32'sd0) else $error("bad divisor");
endmodule
